// ===== rtl/core/pts_pkg.sv =====
// Shared types, codes and arithmetic helpers of the tone and scale sequencer.
package pts_pkg;

   localparam int FREQ_W  = 16;
   localparam int DUTY_W  = 16;
   localparam int PCT_W   = 7;
   localparam int DUR_W   = 32;
   localparam int NOTE_W  = 5;
   localparam int RES_W   = 5;
   localparam int PROD_W  = DUTY_W + PCT_W;

   // floor(x / 100) equals (x * DIV100_MUL) >> DIV100_SHIFT for every x below 2^23.
   localparam logic [23:0] DIV100_MUL   = 24'd10737419;
   localparam int          DIV100_SHIFT = 30;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_DUTY  = 3'd2,
      OP_HALF  = 3'd3,
      OP_SCALE = 3'd4,
      OP_STOP  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_TONE  = 2'd1,
      MODE_SCALE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BUSY       = 2'd1,
      STAT_EMPTY      = 2'd2
   } status_type;

   // How the second stage forms the new frequency and duty settings.
   typedef enum logic [1:0] {
      FA_KEEP = 2'd0,
      FA_SET  = 2'd1,
      FA_MEM  = 2'd2
   } freq_act_type;

   typedef enum logic [1:0] {
      DA_KEEP = 2'd0,
      DA_SET  = 2'd1,
      DA_PCT  = 2'd2
   } duty_act_type;

   typedef struct packed {
      freq_act_type        freq_act;
      logic [FREQ_W-1:0]   freq_val;
      duty_act_type        duty_act;
      logic [DUTY_W-1:0]   duty_val;
      logic [PROD_W-1:0]   duty_prod;
      logic                busy;
      status_type          status;
      logic                finished;
      logic [3:0]          note_pos;
   } stage_type;

   function automatic logic [DUTY_W-1:0] full_scale(input logic [RES_W-1:0] bits);
      logic [RES_W-1:0] b;
      logic [DUTY_W:0]  p;
      b = bits;
      if (b < 5'd1) begin
         b = 5'd1;
      end
      if (b > 5'd16) begin
         b = 5'd16;
      end
      p = (DUTY_W+1)'(1) << b;
      return DUTY_W'(p - (DUTY_W+1)'(1));
   endfunction

   function automatic logic [DUTY_W-1:0] div100(input logic [PROD_W-1:0] x);
      logic [PROD_W+23:0] m;
      m = (PROD_W+24)'(x) * (PROD_W+24)'(DIV100_MUL);
      return DUTY_W'(m >> DIV100_SHIFT);
   endfunction

endpackage

// ===== rtl/core/pts_note_mem.sv =====
// Note table: single-port-write, registered-read synchronous memory.
module pts_note_mem #(
   parameter int MAX_NOTES = 16,
   parameter int IDX_W     = 4
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [pts_pkg::FREQ_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [pts_pkg::FREQ_W-1:0] rd_data
);

   logic [pts_pkg::FREQ_W-1:0] mem [MAX_NOTES];
   logic [pts_pkg::FREQ_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pts_ctrl.sv =====
// First stage: play state, timing, command decode and note table addressing.
module pts_ctrl #(
   parameter int MAX_NOTES = 16,
   parameter int IDX_W     = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pts_pkg::RES_W-1:0]  csr_data,
   input  logic                       accept,
   input  logic [2:0]                 req_opcode,
   input  logic [pts_pkg::FREQ_W-1:0] req_frequency,
   input  logic [pts_pkg::PCT_W-1:0]  req_duty_percent,
   input  logic [pts_pkg::DUR_W-1:0]  req_duration,
   input  logic [3:0]                 req_note_index,
   input  logic [4:0]                 req_note_count,
   input  logic                       req_direction_up,
   output logic                       mem_wr_en,
   output logic [IDX_W-1:0]           mem_wr_addr,
   output logic [pts_pkg::FREQ_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [IDX_W-1:0]           mem_rd_addr,
   output pts_pkg::stage_type         stage_in
);

   localparam logic [8:0] MAX_N9 = 9'(MAX_NOTES);

   logic [pts_pkg::RES_W-1:0]  res_bits_ff;
   pts_pkg::mode_type          mode_ff, mode_in;
   logic [pts_pkg::DUR_W-1:0]  elapsed_ff, elapsed_in;
   logic [pts_pkg::DUR_W-1:0]  active_dur_ff, active_dur_in;
   logic [pts_pkg::NOTE_W-1:0] scale_len_ff, scale_len_in;
   logic [pts_pkg::NOTE_W-1:0] cur_note_ff, cur_note_in;
   logic                       scale_up_ff, scale_up_in;

   logic [pts_pkg::DUTY_W-1:0] mx;
   logic [pts_pkg::DUR_W-1:0]  elapsed_inc;
   logic [pts_pkg::NOTE_W-1:0] note_up;
   logic [pts_pkg::NOTE_W-1:0] note_dn;
   logic [pts_pkg::NOTE_W-1:0] count_cl;
   logic [pts_pkg::PCT_W-1:0]  pct_cl;
   logic                       busy;

   assign csr_ready   = 1'b1;
   assign mem_wr_addr = IDX_W'(req_note_index);
   assign mem_wr_data = req_frequency;
   assign mem_rd_en   = accept;

   always_comb begin
      mx          = pts_pkg::full_scale(res_bits_ff);
      busy        = (mode_ff != pts_pkg::MODE_IDLE);
      elapsed_inc = (elapsed_ff == {pts_pkg::DUR_W{1'b1}}) ? elapsed_ff
                                                           : elapsed_ff + 32'd1;
      note_up     = cur_note_ff + 5'd1;
      note_dn     = cur_note_ff - 5'd1;
      count_cl    = ({4'd0, req_note_count} > MAX_N9) ? 5'(MAX_NOTES) : req_note_count;
      pct_cl      = (req_duty_percent > 7'd100) ? 7'd100 : req_duty_percent;

      mode_in       = mode_ff;
      elapsed_in    = elapsed_ff;
      active_dur_in = active_dur_ff;
      scale_len_in  = scale_len_ff;
      cur_note_in   = cur_note_ff;
      scale_up_in   = scale_up_ff;
      mem_wr_en     = 1'b0;

      stage_in           = '0;
      stage_in.freq_act  = pts_pkg::FA_KEEP;
      stage_in.duty_act  = pts_pkg::DA_KEEP;
      stage_in.status    = pts_pkg::STAT_OK;
      stage_in.duty_prod = pts_pkg::PROD_W'(mx) * pts_pkg::PROD_W'(pct_cl);

      unique case (req_opcode)
         pts_pkg::OP_TICK: begin
            if (busy) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= active_dur_ff) begin
                  // Tone over, or the current scale note is over.
                  if (mode_ff == pts_pkg::MODE_SCALE &&
                      (scale_up_ff ? (note_up < scale_len_ff) : (cur_note_ff != 5'd0))) begin
                     cur_note_in       = scale_up_ff ? note_up : note_dn;
                     elapsed_in        = '0;
                     stage_in.freq_act = pts_pkg::FA_MEM;
                     stage_in.duty_act = pts_pkg::DA_SET;
                     stage_in.duty_val = mx >> 1;
                  end else begin
                     mode_in           = pts_pkg::MODE_IDLE;
                     elapsed_in        = '0;
                     stage_in.freq_act = pts_pkg::FA_SET;
                     stage_in.duty_act = pts_pkg::DA_SET;
                     stage_in.finished = 1'b1;
                  end
               end
            end
         end
         pts_pkg::OP_LOAD: begin
            mem_wr_en = accept && ({5'd0, req_note_index} < MAX_N9);
         end
         pts_pkg::OP_DUTY, pts_pkg::OP_HALF: begin
            if (busy) begin
               stage_in.status = pts_pkg::STAT_BUSY;
            end else begin
               mode_in           = pts_pkg::MODE_TONE;
               elapsed_in        = '0;
               active_dur_in     = req_duration;
               stage_in.freq_act = pts_pkg::FA_SET;
               stage_in.freq_val = req_frequency;
               if (req_opcode == pts_pkg::OP_DUTY) begin
                  stage_in.duty_act = pts_pkg::DA_PCT;
               end else begin
                  stage_in.duty_act = pts_pkg::DA_SET;
                  stage_in.duty_val = mx >> 1;
               end
            end
         end
         pts_pkg::OP_SCALE: begin
            if (busy) begin
               stage_in.status = pts_pkg::STAT_BUSY;
            end else if (req_note_count == 5'd0) begin
               stage_in.status = pts_pkg::STAT_EMPTY;
            end else begin
               mode_in           = pts_pkg::MODE_SCALE;
               elapsed_in        = '0;
               active_dur_in     = req_duration;
               scale_len_in      = count_cl;
               scale_up_in       = req_direction_up;
               cur_note_in       = req_direction_up ? 5'd0 : count_cl - 5'd1;
               stage_in.freq_act = pts_pkg::FA_MEM;
               stage_in.duty_act = pts_pkg::DA_SET;
               stage_in.duty_val = mx >> 1;
            end
         end
         pts_pkg::OP_STOP: begin
            mode_in           = pts_pkg::MODE_IDLE;
            elapsed_in        = '0;
            stage_in.freq_act = pts_pkg::FA_SET;
            stage_in.duty_act = pts_pkg::DA_SET;
         end
         default: begin
         end
      endcase

      mem_rd_addr       = IDX_W'(cur_note_in);
      stage_in.busy     = (mode_in != pts_pkg::MODE_IDLE);
      stage_in.note_pos = (mode_in == pts_pkg::MODE_SCALE) ? cur_note_in[3:0] : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_bits_ff   <= 5'd10;
         mode_ff       <= pts_pkg::MODE_IDLE;
         elapsed_ff    <= '0;
         active_dur_ff <= '0;
         scale_len_ff  <= '0;
         cur_note_ff   <= '0;
         scale_up_ff   <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            res_bits_ff <= csr_data;
         end
         if (accept) begin
            mode_ff       <= mode_in;
            elapsed_ff    <= elapsed_in;
            active_dur_ff <= active_dur_in;
            scale_len_ff  <= scale_len_in;
            cur_note_ff   <= cur_note_in;
            scale_up_ff   <= scale_up_in;
         end
      end
   end

   a_idle_clears_time: assert property (@(posedge clock) disable iff (reset)
      mode_ff == pts_pkg::MODE_IDLE |-> elapsed_ff == '0)
      else $error("elapsed time not cleared while idle");

   a_note_in_scale: assert property (@(posedge clock) disable iff (reset)
      mode_ff == pts_pkg::MODE_SCALE |-> cur_note_ff < scale_len_ff)
      else $error("scale note outside scale length");

   a_table_write_in_range: assert property (@(posedge clock) disable iff (reset)
      accept && mem_wr_en |-> req_opcode == pts_pkg::OP_LOAD &&
                               {5'd0, req_note_index} < MAX_N9)
      else $error("note table written outside a load request");

endmodule

// ===== rtl/core/pts_out.sv =====
// Second stage: resolves frequency and duty settings and holds the response.
module pts_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  pts_pkg::stage_type         stage_in,
   input  logic [pts_pkg::FREQ_W-1:0] mem_rd_data,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_frequency_out,
   output logic [15:0]                rsp_duty_out,
   output logic                       rsp_busy_res,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_finished,
   output logic [3:0]                 rsp_note_position
);

   logic                       valid_ff;
   pts_pkg::stage_type         stage_ff;
   logic [pts_pkg::FREQ_W-1:0] freq_ff;
   logic [pts_pkg::DUTY_W-1:0] duty_ff;
   logic [pts_pkg::FREQ_W-1:0] freq_now;
   logic [pts_pkg::DUTY_W-1:0] duty_now;

   assign req_ready = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;

   always_comb begin
      unique case (stage_ff.freq_act)
         pts_pkg::FA_SET: freq_now = stage_ff.freq_val;
         pts_pkg::FA_MEM: freq_now = mem_rd_data;
         default:         freq_now = freq_ff;
      endcase
      unique case (stage_ff.duty_act)
         pts_pkg::DA_SET: duty_now = stage_ff.duty_val;
         pts_pkg::DA_PCT: duty_now = pts_pkg::div100(stage_ff.duty_prod);
         default:         duty_now = duty_ff;
      endcase
   end

   assign rsp_frequency_out = freq_now;
   assign rsp_duty_out      = duty_now;
   assign rsp_busy_res      = stage_ff.busy;
   assign rsp_status        = stage_ff.status;
   assign rsp_finished      = stage_ff.finished;
   assign rsp_note_position = stage_ff.note_pos;

   // The held settings follow each response once it has been taken, so the next
   // request in this stage resolves against them.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         freq_ff  <= '0;
         duty_ff  <= '0;
      end else begin
         if (valid_ff && rsp_ready) begin
            freq_ff <= freq_now;
            duty_ff <= duty_now;
         end
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   a_finish_goes_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff && stage_ff.finished |-> !stage_ff.busy && stage_ff.status == pts_pkg::STAT_OK)
      else $error("finished response still busy or rejected");

   a_silent_when_finished: assert property (@(posedge clock) disable iff (reset)
      valid_ff && stage_ff.finished |-> rsp_frequency_out == '0 && rsp_duty_out == '0)
      else $error("output not silent after the end of play");

endmodule

// ===== rtl/core/pwm_tone_and_scale_sequencer.sv =====
// Top level of the buzzer tone and scale sequencer.
// Takes one request of any kind per cycle while responses are taken. Each response is
// presented in the cycle after its request is accepted: the first stage updates the
// play state and reads the note table, the second stage picks up the registered table
// word and divides the duty product by one hundred. A waiting response holds the
// request side only while it is not taken. The user must write duty resolution through
// the csr port only while no request is in flight; the block does not enforce it.
module pwm_tone_and_scale_sequencer #(
   parameter int MAX_NOTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_frequency,
   input  logic [6:0]  req_duty_percent,
   input  logic [31:0] req_duration,
   input  logic [3:0]  req_note_index,
   input  logic [4:0]  req_note_count,
   input  logic        req_direction_up,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_frequency_out,
   output logic [15:0] rsp_duty_out,
   output logic        rsp_busy_res,
   output logic [1:0]  rsp_status,
   output logic        rsp_finished,
   output logic [3:0]  rsp_note_position
);

   localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

   logic                       accept;
   logic                       mem_wr_en;
   logic [IDX_W-1:0]           mem_wr_addr;
   logic [pts_pkg::FREQ_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [IDX_W-1:0]           mem_rd_addr;
   logic [pts_pkg::FREQ_W-1:0] mem_rd_data;
   pts_pkg::stage_type         stage_in;

   assign accept = req_valid && req_ready;

   pts_ctrl #(
      .MAX_NOTES (MAX_NOTES),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .accept           (accept),
      .req_opcode       (req_opcode),
      .req_frequency    (req_frequency),
      .req_duty_percent (req_duty_percent),
      .req_duration     (req_duration),
      .req_note_index   (req_note_index),
      .req_note_count   (req_note_count),
      .req_direction_up (req_direction_up),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .stage_in         (stage_in)
   );

   pts_note_mem #(
      .MAX_NOTES (MAX_NOTES),
      .IDX_W     (IDX_W)
   ) u_note_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pts_out u_out (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .stage_in          (stage_in),
      .mem_rd_data       (mem_rd_data),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frequency_out (rsp_frequency_out),
      .rsp_duty_out      (rsp_duty_out),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_status        (rsp_status),
      .rsp_finished      (rsp_finished),
      .rsp_note_position (rsp_note_position)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the buzzer tone and scale sequencer with a play-state predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int NOTE_SLOTS = 16;
   // Opcodes that the block decodes as no operation.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] freq;
      logic [6:0]  pct;
      logic [31:0] dur;
      logic [3:0]  idx;
      logic [4:0]  count;
      logic        up;
   } buzzer_command_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] duty;
      logic        busy;
      logic [1:0]  status;
      logic        finished;
      logic [3:0]  position;
   } buzzer_setting_type;

   class buzzer_board;
      logic [4:0]         res_bits;
      pts_pkg::mode_type  mode;
      logic [31:0]        elapsed;
      logic [31:0]        span;
      logic [15:0]        notes [NOTE_SLOTS];
      logic [4:0]         scale_len;
      logic [4:0]         note_at;
      logic               scale_up;
      logic [15:0]        freq_now;
      logic [15:0]        duty_now;
      buzzer_setting_type expected_settings [$];
      int                 mismatches;

      function new();
         res_bits   = 5'd10;
         mode       = pts_pkg::MODE_IDLE;
         elapsed    = '0;
         span       = '0;
         scale_len  = '0;
         note_at    = '0;
         scale_up   = 1'b1;
         freq_now   = '0;
         duty_now   = '0;
         mismatches = 0;
         foreach (notes[i]) notes[i] = '0;
      endfunction

      function logic [15:0] max_duty();
         int unsigned b;
         b = res_bits;
         if (b < 1) b = 1;
         if (b > 16) b = 16;
         return 16'((32'd1 << b) - 32'd1);
      endfunction

      function void go_silent();
         mode     = pts_pkg::MODE_IDLE;
         freq_now = '0;
         duty_now = '0;
         elapsed  = '0;
      endfunction

      function void sound_note();
         freq_now = notes[note_at[3:0]];
         duty_now = max_duty() >> 1;
         elapsed  = '0;
      endfunction

      function void accept_command(buzzer_command_type c);
         buzzer_setting_type s;
         logic [1:0]         stat;
         logic               ended;
         logic               last;
         logic               busy;
         logic [31:0]        pct;
         logic [4:0]         cnt;
         stat  = pts_pkg::STAT_OK;
         ended = 1'b0;
         busy  = (mode != pts_pkg::MODE_IDLE);
         case (c.op)
            pts_pkg::OP_TICK: begin
               if (busy) begin
                  if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 32'd1;
                  if (elapsed >= span) begin
                     if (mode == pts_pkg::MODE_SCALE) begin
                        if (scale_up) begin
                           note_at = note_at + 5'd1;
                           last = (note_at >= scale_len);
                        end else begin
                           last = (note_at == 5'd0);
                           if (!last) note_at = note_at - 5'd1;
                        end
                     end else begin
                        last = 1'b1;
                     end
                     if (last) begin
                        go_silent();
                        ended = 1'b1;
                     end else begin
                        sound_note();
                     end
                  end
               end
            end
            pts_pkg::OP_LOAD: begin
               notes[c.idx] = c.freq;
            end
            pts_pkg::OP_DUTY, pts_pkg::OP_HALF: begin
               if (busy) begin
                  stat = pts_pkg::STAT_BUSY;
               end else begin
                  if (c.op == pts_pkg::OP_DUTY) begin
                     pct = (c.pct > 7'd100) ? 32'd100 : 32'(c.pct);
                     duty_now = 16'((32'(max_duty()) * pct) / 32'd100);
                  end else begin
                     duty_now = max_duty() >> 1;
                  end
                  freq_now = c.freq;
                  span     = c.dur;
                  elapsed  = '0;
                  mode     = pts_pkg::MODE_TONE;
               end
            end
            pts_pkg::OP_SCALE: begin
               if (busy) begin
                  stat = pts_pkg::STAT_BUSY;
               end else if (c.count == 5'd0) begin
                  stat = pts_pkg::STAT_EMPTY;
               end else begin
                  cnt       = (c.count > 5'(NOTE_SLOTS)) ? 5'(NOTE_SLOTS) : c.count;
                  scale_len = cnt;
                  scale_up  = c.up;
                  span      = c.dur;
                  note_at   = c.up ? 5'd0 : cnt - 5'd1;
                  mode      = pts_pkg::MODE_SCALE;
                  sound_note();
               end
            end
            pts_pkg::OP_STOP: begin
               go_silent();
            end
            default: begin
            end
         endcase
         s.freq     = freq_now;
         s.duty     = duty_now;
         s.busy     = (mode != pts_pkg::MODE_IDLE);
         s.status   = stat;
         s.finished = ended;
         s.position = (mode == pts_pkg::MODE_SCALE) ? note_at[3:0] : 4'd0;
         expected_settings.push_back(s);
      endfunction

      function void check_setting(buzzer_setting_type got);
         buzzer_setting_type want;
         if (expected_settings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: freq %0d duty %0d busy %0d status %0d",
                        got.freq, got.duty, got.busy, got.status,
                        " fin %0d pos %0d", got.finished, got.position);
            return;
         end
         want = expected_settings.pop_front();
         if (want.freq !== got.freq || want.duty !== got.duty || want.busy !== got.busy ||
             want.status !== got.status || want.finished !== got.finished ||
             want.position !== got.position) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t: expected freq %0d duty %0d busy %0d status %0d",
                        $realtime, want.freq, want.duty, want.busy, want.status,
                        " fin %0d pos %0d", want.finished, want.position);
               $display("   got freq %0d duty %0d busy %0d status %0d fin %0d pos %0d",
                        got.freq, got.duty, got.busy, got.status, got.finished,
                        got.position);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = '0;
   logic [15:0] req_frequency = '0;
   logic [6:0]  req_duty_percent = '0;
   logic [31:0] req_duration = '0;
   logic [3:0]  req_note_index = '0;
   logic [4:0]  req_note_count = '0;
   logic        req_direction_up = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_frequency_out;
   logic [15:0] rsp_duty_out;
   logic        rsp_busy_res;
   logic [1:0]  rsp_status;
   logic        rsp_finished;
   logic [3:0]  rsp_note_position;

   buzzer_board board = new();
   bit          rush = 1'b0;

   pwm_tone_and_scale_sequencer DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_frequency     (req_frequency),
      .req_duty_percent  (req_duty_percent),
      .req_duration      (req_duration),
      .req_note_index    (req_note_index),
      .req_note_count    (req_note_count),
      .req_direction_up  (req_direction_up),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frequency_out (rsp_frequency_out),
      .rsp_duty_out      (rsp_duty_out),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_status        (rsp_status),
      .rsp_finished      (rsp_finished),
      .rsp_note_position (rsp_note_position)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_draw();
      if (rush) return 0;
      return $urandom_range(0, 5);
   endfunction

   function automatic buzzer_command_type make_command(logic [2:0] op, logic [15:0] freq,
                                                       logic [6:0] pct, logic [31:0] dur,
                                                       logic [3:0] idx, logic [4:0] count,
                                                       logic up);
      buzzer_command_type c;
      c.op    = op;
      c.freq  = freq;
      c.pct   = pct;
      c.dur   = dur;
      c.idx   = idx;
      c.count = count;
      c.up    = up;
      return c;
   endfunction

   function automatic buzzer_command_type random_command();
      buzzer_command_type c;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      c.op = pts_pkg::OP_TICK;
      else if (pick < 55) c.op = pts_pkg::OP_LOAD;
      else if (pick < 65) c.op = pts_pkg::OP_DUTY;
      else if (pick < 72) c.op = pts_pkg::OP_HALF;
      else if (pick < 84) c.op = pts_pkg::OP_SCALE;
      else if (pick < 91) c.op = pts_pkg::OP_STOP;
      else if (pick < 96) c.op = OP_SPARE_LO;
      else                c.op = OP_SPARE_HI;
      c.freq  = 16'($urandom_range(0, 65535));
      c.pct   = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 100));
      // Mostly short notes so that tones and scales run to their end.
      c.dur   = ($urandom_range(0, 19) == 0) ? 32'($urandom) : 32'($urandom_range(0, 3));
      c.idx   = 4'($urandom_range(0, 15));
      c.count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 6));
      c.up    = 1'($urandom_range(0, 1));
      return c;
   endfunction

   task automatic send_command(input buzzer_command_type c);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode       <= c.op;
      req_frequency    <= c.freq;
      req_duty_percent <= c.pct;
      req_duration     <= c.dur;
      req_note_index   <= c.idx;
      req_note_count   <= c.count;
      req_direction_up <= c.up;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.accept_command(c);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_settings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_resolution(input logic [4:0] bits);
      settle();
      csr_data  <= bits;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.res_bits = bits;
   endtask

   // Response side: random back-pressure, each accepted response checked in order.
   initial begin
      int                 stall;
      buzzer_setting_type seen;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         seen.freq     = rsp_frequency_out;
         seen.duty     = rsp_duty_out;
         seen.busy     = rsp_busy_res;
         seen.status   = rsp_status;
         seen.finished = rsp_finished;
         seen.position = rsp_note_position;
         board.check_setting(seen);
      end
   end

   initial begin
      logic [4:0] res_plan [6];
      res_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd10, 5'd7};
      res_plan[5] = 5'($urandom_range(0, 31));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset resolution.
      send_command(make_command(pts_pkg::OP_LOAD, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_LOAD, 16'hFFFF, 7'd0, 32'd0, 4'd1, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_DUTY, 16'd440, 7'd127, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_SCALE, 16'd0, 7'd0, 32'd1, 4'd0, 5'd3, 1'b1));
      send_command(make_command(pts_pkg::OP_TICK, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_SCALE, 16'd0, 7'd0, 32'd1, 4'd0, 5'd0, 1'b1));
      send_command(make_command(pts_pkg::OP_HALF, 16'hFFFF, 7'd0, 32'd2, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_DUTY, 16'd1000, 7'd100, 32'd5, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_TICK, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_TICK, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_SCALE, 16'd0, 7'd0, 32'hFFFF_FFFF, 4'd0, 5'd31,
                                1'b1));
      send_command(make_command(pts_pkg::OP_STOP, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_SCALE, 16'd0, 7'd0, 32'd0, 4'd0, 5'd2, 1'b0));
      send_command(make_command(pts_pkg::OP_TICK, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_TICK, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_TICK, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(OP_SPARE_HI, 16'd0, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));
      send_command(make_command(pts_pkg::OP_DUTY, 16'd262, 7'd0, 32'd0, 4'd0, 5'd0, 1'b0));

      for (int p = 0; p < 6; p++) begin
         write_resolution(res_plan[p]);
         // The rest of the note table is filled before any random scale can read it.
         if (p == 0) begin
            for (int i = 2; i < NOTE_SLOTS; i++)
               send_command(make_command(pts_pkg::OP_LOAD, 16'($urandom_range(0, 65535)),
                                         7'd0, 32'd0, 4'(i), 5'd0, 1'b0));
         end
         for (int n = 0; n < 260; n++) begin
            if (n % 50 == 0) rush = ($urandom_range(0, 3) == 0);
            send_command(random_command());
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
